### rtl/core/assert_macros.svh
// Assertion macros for the bit buffer RTL.
// Depends on nothing; included by msb_first_bit_buffer_core, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mbb_pkg.sv
// Package for the MSB-first bit buffer: command codes, item types and sizing.
// Used by mbb_mem, mbb_exec and msb_first_bit_buffer_core; depends on nothing.
package mbb_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int CAP_W            = 13;
    localparam int USED_W           = 13;
    localparam int DATA_W           = 32;
    localparam int CNT_W            = 6;
    localparam int CMD_W            = 3;
    localparam int ROW_W            = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_WR_BITS  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_BITS  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALIGN    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_BYTES = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_BYTES = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REWIND   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              error;
        logic [USED_W-1:0] bytes_used;
    } t_out;

    // Address bits of one pair of 4-byte rows (an even row and the odd row after it).
    function automatic int pair_w(input int bytes);
        int w;
        w = $clog2((bytes + 7) >> 3);
        return (w < 1) ? 1 : w;
    endfunction

endpackage

### rtl/core/mbb_mem.sv
// Two-bank byte store: even 4-byte rows in bank 0, odd rows in bank 1.
// Depends on mbb_pkg for the row width.
module mbb_mem #(
    parameter int PAIR_W = 9
) (
    input  logic                                 i_clk,
    input  logic [1:0][PAIR_W-1:0]               i_rd_addr,
    output logic [1:0][mbb_pkg::ROW_W-1:0]       o_rd_data,
    input  logic [1:0]                           i_we,
    input  logic [1:0][PAIR_W-1:0]               i_wr_addr,
    input  logic [1:0][mbb_pkg::ROW_W-1:0]       i_wr_data
);

    localparam int PAIRS = 1 << PAIR_W;

    logic [mbb_pkg::ROW_W-1:0] r_bank0 [PAIRS];
    logic [mbb_pkg::ROW_W-1:0] r_bank1 [PAIRS];
    logic [mbb_pkg::ROW_W-1:0] r_rd0;
    logic [mbb_pkg::ROW_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we[0]) begin
            r_bank0[i_wr_addr[0]] <= i_wr_data[0];
        end
        r_rd0 <= r_bank0[i_rd_addr[0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_we[1]) begin
            r_bank1[i_wr_addr[1]] <= i_wr_data[1];
        end
        r_rd1 <= r_bank1[i_rd_addr[1]];
    end

    assign o_rd_data[0] = r_rd0;
    assign o_rd_data[1] = r_rd1;

endmodule

### rtl/core/mbb_exec.sv
// Execute stage: checks one item against cursor and capacity, extracts read bits
// and merges write bits into the 8-byte window. Depends on mbb_pkg.
module mbb_exec #(
    parameter int BUFFER_BYTES = mbb_pkg::BUFFER_BYTES_DEF,
    localparam int CUR_W = mbb_pkg::pair_w(BUFFER_BYTES) + 7
) (
    input  mbb_pkg::t_in                 i_item,
    input  logic [CUR_W-1:0]             i_cursor,
    input  logic [mbb_pkg::CAP_W-1:0]    i_cap,
    input  logic [2*mbb_pkg::ROW_W-1:0]  i_window,
    output logic [2*mbb_pkg::ROW_W-1:0]  o_window,
    output logic [1:0]                   o_row_we,
    output logic [CUR_W-1:0]             o_cursor,
    output mbb_pkg::t_out                o_result
);

    localparam int SUM_W = ((CUR_W > 16) ? CUR_W : 16) + 1;
    localparam logic [SUM_W-1:0] LIMIT_BITS = SUM_W'(BUFFER_BYTES * 8);

    logic [SUM_W-1:0]  cap_bits;
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  cur_ext;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  align_sum;
    logic              is_byte;
    logic [5:0]        nbits;
    logic [4:0]        off;
    logic [63:0]       shifted;
    logic [31:0]       rd_bits;
    logic [31:0]       mask32;
    logic [31:0]       d32;
    logic [63:0]       m64;
    logic [63:0]       d64;
    logic              err;
    logic              do_wr;
    logic [31:0]       rd;
    logic [CUR_W-1:0]  cur_next;
    logic [CUR_W:0]    used_sum;

    always_comb begin
        cap_bits  = SUM_W'({i_cap, 3'b000});
        total     = (cap_bits > LIMIT_BITS) ? LIMIT_BITS : cap_bits;
        cur_ext   = SUM_W'(i_cursor);
        is_byte   = (i_item.command == mbb_pkg::CMD_WR_BYTES) ||
                    (i_item.command == mbb_pkg::CMD_RD_BYTES);
        nbits     = is_byte ? {i_item.count[2:0], 3'b000} : i_item.count;
        sum       = cur_ext + SUM_W'(nbits);
        align_sum = SUM_W'({i_cursor[CUR_W-1:3], 3'b111}) + SUM_W'(1);

        // The window starts at the cursor's row; the offset is the cursor within it.
        off     = i_cursor[4:0];
        shifted = i_window << off;
        rd_bits = shifted[63:32] >> (6'd32 - nbits);

        mask32 = ~(32'hFFFF_FFFF >> nbits);
        d32    = i_item.data << (6'd32 - nbits);
        m64    = {mask32, 32'h0} >> off;
        d64    = {d32, 32'h0} >> off;

        err      = 1'b0;
        do_wr    = 1'b0;
        rd       = '0;
        cur_next = i_cursor;

        unique case (i_item.command) inside
            mbb_pkg::CMD_WR_BITS, mbb_pkg::CMD_RD_BITS: begin
                if ((i_item.count > 6'd32) || (sum > total)) begin
                    err = 1'b1;
                end else begin
                    cur_next = sum[CUR_W-1:0];
                    do_wr    = (i_item.command == mbb_pkg::CMD_WR_BITS);
                    rd       = (i_item.command == mbb_pkg::CMD_RD_BITS) ? rd_bits : '0;
                end
            end
            mbb_pkg::CMD_ALIGN: begin
                if (i_cursor[2:0] != 3'd0) begin
                    if (align_sum > total) begin
                        err = 1'b1;
                    end else begin
                        cur_next = align_sum[CUR_W-1:0];
                    end
                end
            end
            mbb_pkg::CMD_WR_BYTES, mbb_pkg::CMD_RD_BYTES: begin
                if ((i_item.count == 6'd0) || (i_item.count > 6'd4) ||
                    (i_cursor[2:0] != 3'd0) || (sum > total)) begin
                    err = 1'b1;
                end else begin
                    cur_next = sum[CUR_W-1:0];
                    do_wr    = (i_item.command == mbb_pkg::CMD_WR_BYTES);
                    rd       = (i_item.command == mbb_pkg::CMD_RD_BYTES) ? rd_bits : '0;
                end
            end
            mbb_pkg::CMD_REWIND: begin
                cur_next = '0;
            end
            default: begin
                err = 1'b1;
            end
        endcase

        used_sum = {1'b0, cur_next} + (CUR_W+1)'(7);

        o_window            = (i_window & ~m64) | (d64 & m64);
        o_row_we[1]         = do_wr && (|m64[63:32]);
        o_row_we[0]         = do_wr && (|m64[31:0]);
        o_cursor            = cur_next;
        o_result.read_value = rd;
        o_result.error      = err;
        o_result.bytes_used = mbb_pkg::USED_W'(used_sum >> 3);
    end

endmodule

### rtl/core/msb_first_bit_buffer_core.sv
// Top level of the MSB-first bit buffer: command handshake, cursor, capacity
// register and store clearing. Depends on mbb_pkg, mbb_mem, mbb_exec, assert_macros.svh.
//
//  channel   ports                          handshake
//  -------   -----------------------------  ---------------------------------
//  command   start, busy, i_item            taken when start and not busy
//  result    o_valid, o_result              shown for one cycle, no stall
//  config    i_cfg_we, i_cfg_data           written when i_cfg_we is high
//
// Each item goes through the registered read of both store banks, then the check,
// merge and write back. The result shows in the cycle after that, when the next item
// may already be taken. After reset the store is cleared one row pair per cycle,
// with busy high. Results cannot be held off by the receiver.
`include "assert_macros.svh"

module msb_first_bit_buffer_core #(
    parameter int BUFFER_BYTES = mbb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  mbb_pkg::t_in               i_item,
    output logic                       o_valid,
    output mbb_pkg::t_out              o_result,
    input  logic                       i_cfg_we,
    input  logic [mbb_pkg::CAP_W-1:0]  i_cfg_data
);

    localparam int PAIR_W = mbb_pkg::pair_w(BUFFER_BYTES);
    localparam int CUR_W  = PAIR_W + 7;
    localparam logic [CUR_W-1:0] CUR_MAX = CUR_W'(BUFFER_BYTES * 8);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [PAIR_W-1:0]               r_clr_addr, n_clr_addr;
    logic [CUR_W-1:0]                r_cursor, n_cursor;
    logic [mbb_pkg::CAP_W-1:0]       r_cap;
    mbb_pkg::t_in                    r_item;
    mbb_pkg::t_out                   r_result;
    logic                            r_valid;

    logic                            accept;
    logic                            row_odd;
    logic [PAIR_W-1:0]               pair;
    logic [1:0][PAIR_W-1:0]          rd_addr;
    logic [1:0][mbb_pkg::ROW_W-1:0]  rd_data;
    logic [1:0]                      mem_we;
    logic [1:0][PAIR_W-1:0]          wr_addr;
    logic [1:0][mbb_pkg::ROW_W-1:0]  wr_data;
    logic [2*mbb_pkg::ROW_W-1:0]     window;
    logic [2*mbb_pkg::ROW_W-1:0]     window_new;
    logic [1:0]                      row_we;
    logic [CUR_W-1:0]                exec_cursor;
    mbb_pkg::t_out                   exec_result;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // The window is the cursor's row and the row after it; they sit in opposite banks.
    assign row_odd    = r_cursor[5];
    assign pair       = r_cursor[CUR_W-2:6];
    assign rd_addr[0] = row_odd ? (pair + PAIR_W'(1)) : pair;
    assign rd_addr[1] = pair;
    assign window     = row_odd ? {rd_data[1], rd_data[0]} : {rd_data[0], rd_data[1]};

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we  = 2'b11;
            wr_addr = {r_clr_addr, r_clr_addr};
            wr_data = '0;
        end else begin
            wr_addr = rd_addr;
            if (row_odd) begin
                mem_we  = {row_we[1], row_we[0]} & {2{r_state == ST_EXEC}};
                wr_data = {window_new[63:32], window_new[31:0]};
            end else begin
                mem_we  = {row_we[0], row_we[1]} & {2{r_state == ST_EXEC}};
                wr_data = {window_new[31:0], window_new[63:32]};
            end
        end
    end

    mbb_mem #(
        .PAIR_W (PAIR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_we      (mem_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mbb_exec #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_exec (
        .i_item   (r_item),
        .i_cursor (r_cursor),
        .i_cap    (r_cap),
        .i_window (window),
        .o_window (window_new),
        .o_row_we (row_we),
        .o_cursor (exec_cursor),
        .o_result (exec_result)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cursor   = r_cursor;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + PAIR_W'(1);
                if (r_clr_addr == {PAIR_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_cursor = exec_cursor;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cursor   <= '0;
            r_cap      <= mbb_pkg::CAP_RESET;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cursor   <= n_cursor;
            r_valid    <= (r_state == ST_EXEC);
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == ST_EXEC) begin
            r_result <= exec_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `MBB_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, r_state == ST_EXEC, o_valid, "item finished without a result")
    `MBB_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, busy && !o_valid, "item or result during store clear")
    `MBB_ASSERT_NOW(a_cursor_in_store, i_clk, i_rst_n, 1'b1, r_cursor <= CUR_MAX, "cursor beyond the store")
    `MBB_ASSERT_NOW(a_error_keeps_cursor, i_clk, i_rst_n, o_valid && o_result.error, r_cursor == $past(r_cursor), "refused item moved the cursor")

endmodule

### sim/tb_top.sv
// Self-checking testbench for msb_first_bit_buffer_core: a directed table, then random phases.
// Each phase runs at its own capacity. Depends on mbb_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbb_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int PHASE_ITEMS    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        t_in  item;
        logic exact;
        t_out want;
    } t_script_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    t_in                i_item     = '0;
    logic               i_cfg_we   = 1'b0;
    logic [CAP_W-1:0]   i_cfg_data = '0;
    logic               busy;
    logic               o_valid;
    t_out               o_result;

    // Shadow copy of the buffer state, updated when an item is accepted.
    bit [7:0]           shadow_store [BUFFER_BYTES_DEF];
    int unsigned        shadow_cursor = 0;
    int unsigned        shadow_cap    = int'(CAP_RESET);

    t_out               due_results [$];
    int                 n_fail   = 0;
    int                 n_cycles = 0;
    bit                 no_idle  = 1'b0;

    int unsigned        phase_caps [8] = '{8191, 0, 1, 7, 4095, 13, 4096, 40};

    t_script_row        script [25] = '{
        '{'{CMD_REWIND,   32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd0}},
        '{'{CMD_RD_BITS,  32'h1234_5678, 6'd32}, 1'b1, '{32'h0000_0000, 1'b0, 13'd4}},
        '{'{CMD_REWIND,   32'hFFFF_FFFF, 6'd63}, 1'b1, '{32'h0000_0000, 1'b0, 13'd0}},
        '{'{CMD_WR_BITS,  32'hFFFF_FFFF, 6'd32}, 1'b1, '{32'h0000_0000, 1'b0, 13'd4}},
        '{'{CMD_REWIND,   32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd0}},
        '{'{CMD_RD_BITS,  32'h0000_0000, 6'd32}, 1'b1, '{32'hFFFF_FFFF, 1'b0, 13'd4}},
        '{'{CMD_WR_BITS,  32'hFFFF_FFFF, 6'd33}, 1'b1, '{32'h0000_0000, 1'b1, 13'd4}},
        '{'{CMD_WR_BITS,  32'h0000_0001, 6'd63}, 1'b1, '{32'h0000_0000, 1'b1, 13'd4}},
        '{'{CMD_RD_BITS,  32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd4}},
        '{'{CMD_WR_BITS,  32'hFFFF_FFFD, 6'd3},  1'b1, '{32'h0000_0000, 1'b0, 13'd5}},
        '{'{CMD_WR_BYTES, 32'h0000_00AA, 6'd1},  1'b1, '{32'h0000_0000, 1'b1, 13'd5}},
        '{'{CMD_RD_BYTES, 32'h0000_0000, 6'd2},  1'b1, '{32'h0000_0000, 1'b1, 13'd5}},
        '{'{CMD_ALIGN,    32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd5}},
        '{'{CMD_ALIGN,    32'hFFFF_FFFF, 6'd32}, 1'b1, '{32'h0000_0000, 1'b0, 13'd5}},
        '{'{CMD_WR_BYTES, 32'h1111_1111, 6'd0},  1'b1, '{32'h0000_0000, 1'b1, 13'd5}},
        '{'{CMD_WR_BYTES, 32'h2222_2222, 6'd5},  1'b1, '{32'h0000_0000, 1'b1, 13'd5}},
        '{'{CMD_WR_BYTES, 32'hDEAD_BEEF, 6'd4},  1'b0, '0},
        '{'{CMD_WR_BYTES, 32'h7654_32A5, 6'd1},  1'b0, '0},
        '{'{CMD_SPARE_6,  32'h0000_0000, 6'd1},  1'b1, '{32'h0000_0000, 1'b1, 13'd10}},
        '{'{CMD_SPARE_7,  32'hFFFF_FFFF, 6'd4},  1'b1, '{32'h0000_0000, 1'b1, 13'd10}},
        '{'{CMD_REWIND,   32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd0}},
        '{'{CMD_RD_BYTES, 32'h0000_0000, 6'd4},  1'b1, '{32'hFFFF_FFFF, 1'b0, 13'd4}},
        '{'{CMD_RD_BITS,  32'h0000_0000, 6'd3},  1'b1, '{32'h0000_0005, 1'b0, 13'd5}},
        '{'{CMD_ALIGN,    32'h0000_0000, 6'd0},  1'b1, '{32'h0000_0000, 1'b0, 13'd5}},
        '{'{CMD_RD_BYTES, 32'h0000_0000, 6'd4},  1'b1, '{32'hDEAD_BEEF, 1'b0, 13'd9}}
    };

    msb_first_bit_buffer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Applies one command to the shadow state and returns the result it should give.
    function automatic t_out apply_command(input t_in it);
        t_out        r;
        int unsigned limit_bits;
        int unsigned cnt;
        int unsigned pos;
        int unsigned idx;
        int unsigned sh;
        int unsigned used;
        logic [31:0] rd;
        bit          err;
        limit_bits = ((shadow_cap > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : shadow_cap) * 8;
        cnt = it.count;
        rd  = '0;
        err = 1'b0;
        case (it.command)
            CMD_WR_BITS, CMD_RD_BITS: begin
                if (cnt > 32 || shadow_cursor + cnt > limit_bits) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        idx = shadow_cursor >> 3;
                        sh  = 7 - (shadow_cursor & 7);
                        if (it.command == CMD_WR_BITS) begin
                            shadow_store[idx][sh] = it.data[cnt - 1 - i];
                        end else begin
                            rd = {rd[30:0], shadow_store[idx][sh]};
                        end
                        shadow_cursor++;
                    end
                end
            end
            CMD_ALIGN: begin
                if ((shadow_cursor & 7) != 0) begin
                    if (shadow_cursor + (8 - (shadow_cursor & 7)) > limit_bits) begin
                        err = 1'b1;
                    end else begin
                        shadow_cursor += 8 - (shadow_cursor & 7);
                    end
                end
            end
            CMD_WR_BYTES, CMD_RD_BYTES: begin
                pos = shadow_cursor >> 3;
                if (cnt < 1 || cnt > 4 || (shadow_cursor & 7) != 0 ||
                        (pos + cnt) * 8 > limit_bits) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        if (it.command == CMD_WR_BYTES) begin
                            shadow_store[pos + i] = it.data[8 * (cnt - 1 - i) +: 8];
                        end else begin
                            rd = {rd[23:0], shadow_store[pos + i]};
                        end
                    end
                    shadow_cursor += cnt * 8;
                end
            end
            CMD_REWIND: begin
                shadow_cursor = 0;
            end
            default: begin
                err = 1'b1;
            end
        endcase
        used = (shadow_cursor + 7) >> 3;
        r.read_value = err ? '0 : rd;
        r.error      = err;
        r.bytes_used = used[USED_W-1:0];
        return r;
    endfunction

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int bit_count();
        if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 0) ? 0 : 32;
        return $urandom_range(1, 32);
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  r;
        r = $urandom_range(0, 99);
        it.data  = $urandom;
        it.count = CNT_W'($urandom_range(0, 63));
        if (r < 28) begin
            it.command = CMD_WR_BITS;
            it.count   = CNT_W'(bit_count());
        end else if (r < 52) begin
            it.command = CMD_RD_BITS;
            it.count   = CNT_W'(bit_count());
        end else if (r < 60) begin
            it.command = CMD_ALIGN;
        end else if (r < 74) begin
            it.command = CMD_WR_BYTES;
            it.count   = CNT_W'($urandom_range(1, 4));
        end else if (r < 88) begin
            it.command = CMD_RD_BYTES;
            it.count   = CNT_W'($urandom_range(1, 4));
        end else if (r < 93) begin
            it.command = CMD_REWIND;
        end else begin
            // Broken items: any code, any count.
            it.command = CMD_W'($urandom_range(0, 7));
        end
        return it;
    endfunction

    // Start stays high across back-to-back items; this task only drops it for a gap.
    task automatic send_item(input t_in it, input bit exact, input t_out want);
        int   gap;
        t_out predicted;
        gap = idle_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = apply_command(it);
        due_results.push_back(exact ? want : predicted);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input int unsigned cap);
        wait_results_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap[CAP_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_cap = cap;
    endtask

    initial begin
        t_in it;
        t_in pad;
        int  sent;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 25; k++) begin
            send_item(script[k].item, script[k].exact, script[k].want);
        end

        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                it = random_item();
                // Byte commands usually get a pad first so they are not simply refused.
                if ((it.command == CMD_WR_BYTES || it.command == CMD_RD_BYTES) &&
                        $urandom_range(0, 3) != 0) begin
                    pad.command = CMD_ALIGN;
                    pad.data    = $urandom;
                    pad.count   = '0;
                    send_item(pad, 1'b0, '0);
                    sent++;
                end
                send_item(it, 1'b0, '0);
                sent++;
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none due, actual %h", $time, o_result);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                if (o_result.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_result.read_value);
                    n_fail++;
                end
                if (o_result.error !== want.error) begin
                    $display("%0t: error expected %b actual %b",
                             $time, want.error, o_result.error);
                    n_fail++;
                end
                if (o_result.bytes_used !== want.bytes_used) begin
                    $display("%0t: bytes_used expected %0d actual %0d",
                             $time, want.bytes_used, o_result.bytes_used);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("FAIL");
            $finish;
        end
    end

endmodule
